// File: hdl/tbsc_pkg.sv
// shared constants, types and coefficient table for the tape bias slew cascade
package tbsc_pkg;

    // sample format and cascade size
    localparam int STAGES      = 9;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC        = SAMPLE_BITS - 1;
    localparam int IDX_W       = (STAGES > 1) ? $clog2(STAGES) : 1;

    // configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_BASE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STICK_ENABLE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STICK_RECIP  = CFG_IDX_W'(2);
    localparam logic [31:0] SLEW_BASE_RST = 32'h0100_0000;

    // threshold: base (Q8.24) times phi^k (Q.20), scaled down to sample lsbs
    localparam int PHI_W  = 32;
    localparam int TSHIFT = 44 - FRAC;
    localparam int T_W    = 64 - TSHIFT;

    // working widths: pull target, x minus target, clamp arithmetic
    localparam int P_W = SAMPLE_BITS + 2;
    localparam int D_W = SAMPLE_BITS + 3;
    localparam int C_W = ((T_W > D_W) ? T_W : D_W) + 2;

    // s*40/39 by reciprocal multiply, one correction step
    localparam int A39_W = SAMPLE_BITS + 6;
    localparam int N39   = A39_W;
    localparam int M39_W = SAMPLE_BITS + 1;
    localparam logic [M39_W-1:0] M39 = M39_W'((64'd1 << N39) / 64'd39);

    // x*39/40 as ((x*39+20)>>3)/5 by reciprocal multiply, one correction step
    localparam int B5_W = SAMPLE_BITS + 3;
    localparam int N5   = B5_W;
    localparam int M5_W = SAMPLE_BITS + 1;
    localparam logic [M5_W-1:0] M5 = M5_W'((64'd1 << N5) / 64'd5);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STAGES - 1);
    localparam logic [3:0]       K_TOP    = 4'(STAGES - 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic [31:0] slew_base;
        logic        stick_enable;
        logic [31:0] stick_recip;
    } t_cfg;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        t_sample          wdata;
    } t_mem_req;

    // golden ratio powers in Q.20, rounded to nearest
    function automatic logic [PHI_W-1:0] phi_q20(input logic [3:0] k);
        logic [PHI_W-1:0] v;
        unique case (k)
            4'd0:  v = 32'd1048576;
            4'd1:  v = 32'd1696632;
            4'd2:  v = 32'd2745208;
            4'd3:  v = 32'd4441839;
            4'd4:  v = 32'd7187047;
            4'd5:  v = 32'd11628886;
            4'd6:  v = 32'd18815933;
            4'd7:  v = 32'd30444819;
            4'd8:  v = 32'd49260752;
            4'd9:  v = 32'd79705571;
            4'd10: v = 32'd128966322;
            4'd11: v = 32'd208671893;
            4'd12: v = 32'd337638216;
            4'd13: v = 32'd546310109;
            4'd14: v = 32'd883948324;
            4'd15: v = 32'd1430258433;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/tbsc_state_mem.sv
// per-stage stored value memory, one port, registered read, valid bits for reset
module tbsc_state_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbsc_pkg::t_mem_req   i_req,
    output tbsc_pkg::t_sample    o_rdata
);
    import tbsc_pkg::*;

    t_sample            r_mem [STAGES];
    logic [STAGES-1:0]  r_valid;
    t_sample            r_rdata;
    logic               r_rd_hit;

    // storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    // entry valid bits, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_valid[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rd_hit ? r_rdata : '0;

endmodule

// File: hdl/tbsc_engine.sv
// stage sequencer and datapath: read, pull, clamp, scale and write back each stage
module tbsc_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbsc_pkg::t_cfg       i_cfg,
    input  logic                 i_start,
    input  tbsc_pkg::t_sample    i_sample,
    output logic                 o_busy,
    output logic                 o_done,
    input  logic                 i_done_ack,
    output tbsc_pkg::t_sample    o_result,
    output tbsc_pkg::t_mem_req   o_mem_req,
    input  tbsc_pkg::t_sample    i_mem_rdata
);
    import tbsc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_PA,
        ST_PM,
        ST_PQ,
        ST_ST1,
        ST_SM,
        ST_SC,
        ST_BM,
        ST_BA,
        ST_CL,
        ST_W0,
        ST_W1,
        ST_W2,
        ST_DONE
    } t_state;

    localparam int PR39_W = A39_W + M39_W;
    localparam int PR5_W  = B5_W + M5_W;
    localparam int PRST_W = D_W + 32;
    localparam int PRBL_W = D_W + FRAC + 1;
    localparam logic signed [PRBL_W-1:0] BL_HALF = PRBL_W'(64'd1 << (FRAC - 1));
    localparam logic signed [C_W-1:0] C_SMAX = C_W'((64'sd1 <<< FRAC) - 64'sd1);
    localparam logic signed [C_W-1:0] C_SMIN = C_W'(-(64'sd1 <<< FRAC));

    t_state             r_state;
    logic [IDX_W-1:0]   r_idx;

    // datapath registers
    logic signed [D_W-1:0]  r_x;
    t_sample                r_s;
    logic [63:0]            r_tprod;
    logic [T_W-1:0]         r_t;
    logic [A39_W-1:0]       r_a39;
    logic [PR39_W-1:0]      r_pr39;
    logic signed [P_W-1:0]  r_p;
    logic signed [D_W-1:0]  r_dxp;
    logic [D_W-1:0]         r_dmag;
    logic [PRST_W-1:0]      r_prst;
    logic [FRAC-1:0]        r_st;
    logic signed [PRBL_W-1:0] r_prbl;
    t_sample                r_y;
    logic [B5_W-1:0]        r_b5;
    logic [PR5_W-1:0]       r_pr5;

    // combinational helpers
    logic [3:0]             phi_k;
    logic [SAMPLE_BITS-1:0] s_mag;
    logic [A39_W-1:0]       a39_next;
    logic [M39_W-1:0]       q39_0;
    logic [A39_W:0]         rem39;
    logic [M39_W-1:0]       q39;
    logic signed [P_W-1:0]  p_mag_s;
    logic signed [P_W-1:0]  p_next;
    logic signed [D_W-1:0]  p_ext;
    logic signed [D_W-1:0]  dxp_next;
    logic [D_W-1:0]         dmag_next;
    logic                   st_small;
    logic signed [FRAC:0]   st_s;
    logic signed [PRBL_W-1:0] prbl_next;
    logic signed [PRBL_W-1:0] bl_sum;
    logic signed [PRBL_W-1:0] bl_q;
    logic signed [D_W-1:0]  bl_step;
    logic signed [D_W-1:0]  x_bl;
    logic signed [C_W-1:0]  c_x;
    logic signed [C_W-1:0]  c_s;
    logic signed [C_W-1:0]  c_t;
    logic signed [C_W-1:0]  c_diff;
    logic signed [C_W-1:0]  c_y;
    t_sample                y_sat;
    logic signed [D_W-1:0]  y_ext;
    logic [SAMPLE_BITS-1:0] y_mag;
    logic [SAMPLE_BITS+5:0] a40;
    logic [M5_W-1:0]        q5_0;
    logic [B5_W:0]          rem5;
    logic [M5_W-1:0]        q5;
    t_sample                w_mag_s;
    t_sample                w_next;

    // threshold exponent, largest for the first stage
    assign phi_k = K_TOP - 4'(r_idx);

    // pull target p = round(s*40/39)
    assign s_mag    = i_mem_rdata[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_mem_rdata)
                                                 : SAMPLE_BITS'(i_mem_rdata);
    assign a39_next = A39_W'(s_mag) * A39_W'(40) + A39_W'(19);
    assign q39_0    = r_pr39[PR39_W-1:N39];
    assign rem39    = {1'b0, r_a39} - (A39_W+1)'(q39_0) * (A39_W+1)'(39);
    assign q39      = q39_0 + M39_W'(rem39 >= (A39_W+1)'(39));
    assign p_mag_s  = P_W'(q39);
    assign p_next   = r_s[SAMPLE_BITS-1] ? -p_mag_s : p_mag_s;
    assign p_ext    = r_p;

    // stick factor st = floor(|x - p| * recip / 2^16)
    assign dxp_next  = r_x - p_ext;
    assign dmag_next = dxp_next[D_W-1] ? D_W'(-dxp_next) : D_W'(dxp_next);
    assign st_small  = (r_prst[PRST_W-1:16+FRAC] == '0);

    // blend x = p + round((x - p) * st)
    assign st_s      = {1'b0, r_st};
    assign prbl_next = r_dxp * st_s;
    assign bl_sum    = r_prbl + BL_HALF;
    assign bl_q      = bl_sum >>> FRAC;
    assign bl_step   = bl_q[D_W-1:0];
    assign x_bl      = p_ext + bl_step;

    // step clamp against stored value, then saturate
    assign c_x    = r_x;
    assign c_s    = r_s;
    assign c_t    = C_W'(r_t);
    assign c_diff = c_x - c_s;

    always_comb begin
        priority if (c_diff > c_t) begin
            c_y = c_s + c_t;
        end else if (-c_diff > c_t) begin
            c_y = c_s - c_t;
        end else begin
            c_y = c_x;
        end
    end

    always_comb begin
        priority if (c_y > C_SMAX) begin
            y_sat = C_SMAX[SAMPLE_BITS-1:0];
        end else if (c_y < C_SMIN) begin
            y_sat = C_SMIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = c_y[SAMPLE_BITS-1:0];
        end
    end

    assign y_ext = y_sat;

    // stored value round(y*39/40)
    assign y_mag   = r_y[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_y) : SAMPLE_BITS'(r_y);
    assign a40     = (SAMPLE_BITS+6)'(y_mag) * (SAMPLE_BITS+6)'(39) + (SAMPLE_BITS+6)'(20);
    assign q5_0    = r_pr5[PR5_W-1:N5];
    assign rem5    = {1'b0, r_b5} - (B5_W+1)'(q5_0) * (B5_W+1)'(5);
    assign q5      = q5_0 + M5_W'(rem5 >= (B5_W+1)'(5));
    assign w_mag_s = q5[SAMPLE_BITS-1:0];
    assign w_next  = r_y[SAMPLE_BITS-1] ? -w_mag_s : w_mag_s;

    // stage sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_idx   <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD:  r_state <= ST_PA;
                ST_PA:  r_state <= ST_PM;
                ST_PM:  r_state <= ST_PQ;
                ST_PQ:  r_state <= i_cfg.stick_enable ? ST_ST1 : ST_CL;
                ST_ST1: r_state <= ST_SM;
                ST_SM:  r_state <= ST_SC;
                ST_SC:  r_state <= st_small ? ST_BM : ST_CL;
                ST_BM:  r_state <= ST_BA;
                ST_BA:  r_state <= ST_CL;
                ST_CL:  r_state <= ST_W0;
                ST_W0:  r_state <= ST_W1;
                ST_W1:  r_state <= ST_W2;
                ST_W2: begin
                    if (r_idx == IDX_LAST) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= ST_RD;
                    end
                end
                ST_DONE: begin
                    if (i_done_ack) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath loads per step
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_x <= D_W'(i_sample);
        end
        if (r_state == ST_RD) begin
            r_tprod <= 64'(i_cfg.slew_base) * 64'(phi_q20(phi_k));
        end
        if (r_state == ST_PA) begin
            r_s   <= i_mem_rdata;
            r_a39 <= a39_next;
            r_t   <= r_tprod[63:TSHIFT];
        end
        if (r_state == ST_PM) begin
            r_pr39 <= PR39_W'(r_a39) * PR39_W'(M39);
        end
        if (r_state == ST_PQ) begin
            r_p <= p_next;
        end
        if (r_state == ST_ST1) begin
            r_dxp  <= dxp_next;
            r_dmag <= dmag_next;
        end
        if (r_state == ST_SM) begin
            r_prst <= PRST_W'(r_dmag) * PRST_W'(i_cfg.stick_recip);
        end
        if (r_state == ST_SC) begin
            r_st <= r_prst[16+FRAC-1:16];
        end
        if (r_state == ST_BM) begin
            r_prbl <= prbl_next;
        end
        if (r_state == ST_BA) begin
            r_x <= x_bl;
        end
        if (r_state == ST_CL) begin
            r_y <= y_sat;
            r_x <= y_ext;
        end
        if (r_state == ST_W0) begin
            r_b5 <= B5_W'(a40 >> 3);
        end
        if (r_state == ST_W1) begin
            r_pr5 <= PR5_W'(r_b5) * PR5_W'(M5);
        end
    end

    // memory requests
    always_comb begin
        o_mem_req.rd_en = (r_state == ST_RD);
        o_mem_req.wr_en = (r_state == ST_W2);
        o_mem_req.addr  = r_idx;
        o_mem_req.wdata = w_next;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = (r_state == ST_DONE);
    assign o_result = r_y;

    // checks
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.rd_en && o_mem_req.wr_en))
        else $error("state memory read and write in the same cycle");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.rd_en || o_mem_req.wr_en) |-> (o_mem_req.addr <= IDX_LAST))
        else $error("state memory address beyond last stage");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.wr_en && (o_mem_req.addr == IDX_LAST)) |=> o_done)
        else $error("last stage written but result not presented");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("request started while cascade busy");

endmodule

// File: hdl/tape_bias_slew_cascade.sv
// top level: config registers, request handshake, result register
//
// mono slew-limiter cascade with optional underbias stick blending.
// input channel: i_in_valid / o_in_stall carry one sample request
// (i_sample_in, i_block_last); it is taken at an edge with valid high
// and stall low. output channel: o_out_valid / i_out_stall carry the
// processed sample and the echoed block marker.
// each request walks the nine stages one after another through a
// single-port state memory, reading, pulling, clamping and writing
// back each stage; with stick on, a stage also forms the stick factor
// and blends when the pull applies. the next request is taken only
// after the result moves to the output register. a finished result
// waits in the output register while the receiver stalls; the cascade
// meanwhile takes and processes the next request. reset clears stage
// state to zero, slew_base to 1.0 and stick off. config writes go
// through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user is to make them
// only while idle, which the block itself does not enforce.
module tape_bias_slew_cascade (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [tbsc_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [tbsc_pkg::CFG_W-1:0]               i_cfg_wdata,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [tbsc_pkg::SAMPLE_BITS-1:0]  i_sample_in,
    input  logic                                     i_block_last,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [tbsc_pkg::SAMPLE_BITS-1:0]  o_sample_out,
    output logic                                     o_block_end
);
    import tbsc_pkg::*;

    t_cfg       r_cfg;
    logic       r_last;
    logic       r_out_valid;
    t_sample    r_out_sample;
    logic       r_out_last;

    logic       in_acc;
    logic       out_pop;
    logic       res_load;
    logic       eng_busy;
    logic       eng_done;
    t_sample    eng_result;
    t_mem_req   mem_req;
    t_sample    mem_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slew_base    <= SLEW_BASE_RST;
            r_cfg.stick_enable <= 1'b0;
            r_cfg.stick_recip  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SLEW_BASE:    r_cfg.slew_base    <= i_cfg_wdata[31:0];
                REG_STICK_ENABLE: r_cfg.stick_enable <= i_cfg_wdata[0];
                REG_STICK_RECIP:  r_cfg.stick_recip  <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // request side
    assign o_in_stall = eng_busy;
    assign in_acc     = i_in_valid && !eng_busy;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last <= i_block_last;
        end
    end

    // result register, filled when empty or being drained
    assign out_pop  = r_out_valid && !i_out_stall;
    assign res_load = eng_done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_sample <= eng_result;
            r_out_last   <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_block_end  = r_out_last;

    tbsc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (in_acc),
        .i_sample    (i_sample_in),
        .o_busy      (eng_busy),
        .o_done      (eng_done),
        .i_done_ack  (res_load),
        .o_result    (eng_result),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    tbsc_state_mem u_state_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the tape bias slew cascade: directed table, random phases
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbsc_pkg::*;

    localparam int     PHASES       = 10;
    localparam int     PHASE_ITEMS  = 163;
    localparam int     HOLD_CYCLES  = 500;
    localparam int     IDLE_LIMIT   = 3000;
    localparam int     TAIL_CYCLES  = 200;
    localparam longint UNITY        = 64'sd1 <<< FRAC;
    localparam longint SMAX         = UNITY - 1;
    localparam longint SMIN         = -UNITY;
    localparam int     SAMPLE_MAX   = 8388607;
    localparam int     SAMPLE_MIN   = -8388608;

    // golden ratio powers in Q.20
    localparam logic [63:0] PHI_POW [16] = '{
        64'd1048576, 64'd1696632, 64'd2745208, 64'd4441839,
        64'd7187047, 64'd11628886, 64'd18815933, 64'd30444819,
        64'd49260752, 64'd79705571, 64'd128966322, 64'd208671893,
        64'd337638216, 64'd546310109, 64'd883948324, 64'd1430258433
    };

    typedef struct packed {
        t_sample smp;
        logic    last;
    } t_cascade_result;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [31:0]            wdata;
        int                     smp;
        bit                     last;
        bit                     has_exp;
        int                     exp_smp;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_wdata;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_sample                i_sample_in;
    logic                   i_block_last;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_sample                o_sample_out;
    logic                   o_block_end;

    // predictor copy of registers and stage memory
    logic [31:0]        cfg_base;
    logic               cfg_stick;
    logic [31:0]        cfg_recip;
    longint             stage_mem [STAGES];

    t_cascade_result    cascade_out_q [$];
    t_cascade_result    head_r;
    t_dir_row           dir_tab [33];
    t_sample            walk_val;
    int                 err_cnt;
    int                 idle_cycles;
    int                 outs_seen;
    bit                 burst_in;
    bit                 burst_out;
    bit                 hold_req;

    tape_bias_slew_cascade dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_block_last (i_block_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_block_end  (o_block_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // n/d rounded to nearest, ties away from zero
    function automatic longint round_near(input longint n, input longint den);
        if (n >= 0) return (n + den / 2) / den;
        return -((-n + den / 2) / den);
    endfunction

    // push one sample through all stages, updating the stage memory
    function automatic t_sample run_cascade(input t_sample smp);
        longint             x;
        longint             s;
        longint             t;
        longint             p;
        longint             diff;
        longint             acc;
        longint unsigned    d;
        longint unsigned    st;
        int                 k;
        x = longint'(smp);
        for (int i = 0; i < STAGES; i++) begin
            s = stage_mem[i];
            k = STAGES - 1 - i;
            t = longint'((64'(cfg_base) * PHI_POW[k]) >> (44 - FRAC));
            // underbias: pull toward previous output when close enough
            if (cfg_stick) begin
                p = round_near(s * 40, 39);
                diff = x - p;
                d = (diff < 0) ? -diff : diff;
                st = d * 64'(cfg_recip >> 16) + ((d * 64'(cfg_recip & 32'hFFFF)) >> 16);
                if (st < UNITY) begin
                    acc = x * longint'(st) + p * (UNITY - longint'(st)) + UNITY / 2;
                    x = acc >>> FRAC;
                end
            end
            // slew clamp around the stored value, then saturate
            if (x - s > t) x = s + t;
            if (s - x > t) x = s - t;
            if (x > SMAX) x = SMAX;
            if (x < SMIN) x = SMIN;
            stage_mem[i] = round_near(x * 39, 40);
        end
        return SAMPLE_BITS'(x);
    endfunction

    // register write, mirrored into the predictor; write enable is dropped before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_SLEW_BASE:    cfg_base  = val;
            REG_STICK_ENABLE: cfg_stick = val[0];
            REG_STICK_RECIP:  cfg_recip = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop offering requests until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (cascade_out_q.size() != 0);
    endtask

    // offer one request after a random gap (none in a burst), predict once it is taken
    task automatic send_sample(input t_sample smp, input logic last, input bit has_exp,
                               input t_sample exp_smp);
        t_cascade_result r;
        int              gap;
        gap = burst_in ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_sample_in  <= smp;
        i_block_last <= last;
        do @(posedge i_clk); while (o_in_stall);
        r.smp  = run_cascade(smp);
        r.last = last;
        if (has_exp) r.smp = exp_smp;
        cascade_out_q.push_back(r);
        @(negedge i_clk);
    endtask

    // main sequence
    initial begin
        t_sample        smp;
        logic [31:0]    base_v;
        logic [31:0]    recip_v;
        longint         wv;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_sample_in  = '0;
        i_block_last = 1'b0;
        err_cnt      = 0;
        hold_req     = 1'b0;
        burst_in     = 1'b0;
        walk_val     = '0;
        cfg_base     = SLEW_BASE_RST;
        cfg_stick    = 1'b0;
        cfg_recip    = '0;
        foreach (stage_mem[i]) stage_mem[i] = 0;

        dir_tab = '{
            // fresh state passes a sample through unchanged
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, 0, 1'b0, 1'b1, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MIN, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, -1, 1'b1, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, 1, 1'b0, 1'b0, 0},
            // zero threshold: every stage holds
            '{ROW_CFG, REG_SLEW_BASE, 32'h0000_0000, 0, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MAX, 1'b1, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MIN, 1'b0, 1'b0, 0},
            // widest threshold, stage saturation
            '{ROW_CFG, REG_SLEW_BASE, 32'hFFFF_FFFF, 0, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MIN, 1'b1, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MAX, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, 0, 1'b1, 1'b0, 0},
            // tight threshold, heavy slew limiting
            '{ROW_CFG, REG_SLEW_BASE, 32'h0000_1000, 0, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MAX, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MIN, 1'b1, 1'b0, 0},
            // stick on with zero width: sample snaps to pull target
            '{ROW_CFG, REG_STICK_ENABLE, 32'h0000_0001, 0, 1'b0, 1'b0, 0},
            '{ROW_CFG, REG_STICK_RECIP, 32'h0000_0000, 0, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, 12345, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MAX, 1'b1, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MIN, 1'b0, 1'b0, 0},
            // largest reciprocal: pull only very close to the target
            '{ROW_CFG, REG_STICK_RECIP, 32'hFFFF_FFFF, 0, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MAX, 1'b1, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, 0, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MIN, 1'b1, 1'b0, 0},
            // unit reciprocal: partial blend
            '{ROW_CFG, REG_STICK_RECIP, 32'h0001_0000, 0, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, 4000000, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, -4000000, 1'b1, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, 100, 1'b0, 1'b0, 0},
            // back to default threshold, fractional reciprocal
            '{ROW_CFG, REG_SLEW_BASE, SLEW_BASE_RST, 0, 1'b0, 1'b0, 0},
            '{ROW_CFG, REG_STICK_RECIP, 32'h0000_0100, 0, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MIN, 1'b1, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, SAMPLE_MAX, 1'b0, 1'b0, 0},
            '{ROW_SAMPLE, REG_SLEW_BASE, 32'h0, 0, 1'b1, 1'b0, 0}
        };

        // reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                drain_results();
                write_reg(dir_tab[r].reg_idx, dir_tab[r].wdata);
            end else begin
                send_sample(SAMPLE_BITS'(dir_tab[r].smp), dir_tab[r].last,
                            dir_tab[r].has_exp, SAMPLE_BITS'(dir_tab[r].exp_smp));
            end
        end

        // random phases, each with a fresh register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       base_v = 32'h0000_0000;
                1:       base_v = 32'hFFFF_FFFF;
                2:       base_v = SLEW_BASE_RST;
                3:       base_v = $urandom_range(0, 65535);
                4:       base_v = $urandom_range(0, 32'h0100_0000);
                default: base_v = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       recip_v = 32'h0000_0000;
                1:       recip_v = 32'hFFFF_FFFF;
                2:       recip_v = $urandom_range(0, 32'h0001_0000);
                3:       recip_v = $urandom_range(32'h0000_0100, 32'h0010_0000);
                default: recip_v = $urandom;
            endcase
            drain_results();
            write_reg(REG_SLEW_BASE, base_v);
            write_reg(REG_STICK_ENABLE, 32'(ph % 2));
            write_reg(REG_STICK_RECIP, recip_v);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold while requests keep coming
                if (ph == 2 && n == 20) hold_req = 1'b1;
                // sender pause until everything is back
                if (ph == 4 && n == 80) drain_results();
                if (n % 64 == 0) burst_in = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: smp = SAMPLE_BITS'($urandom);
                    8:          smp = SAMPLE_BITS'(int'($urandom_range(0, 510)) - 255);
                    9: begin
                        case ($urandom_range(0, 2))
                            0:       smp = SAMPLE_BITS'(SAMPLE_MAX);
                            1:       smp = SAMPLE_BITS'(SAMPLE_MIN);
                            default: smp = '0;
                        endcase
                    end
                    default: begin
                        // audio-like random walk
                        wv = longint'(walk_val) + longint'($urandom_range(0, 2097152))
                             - 64'sd1048576;
                        if (wv > SMAX) wv = SMAX;
                        if (wv < SMIN) wv = SMIN;
                        walk_val = SAMPLE_BITS'(wv);
                        smp = walk_val;
                    end
                endcase
                send_sample(smp, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // receiver: random stalls, bursts without stalls, one long hold
    initial begin
        int wait_n;
        i_out_stall = 1'b0;
        outs_seen   = 0;
        burst_out   = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                wait_n = HOLD_CYCLES;
            end else begin
                if (outs_seen % 64 == 0) burst_out = ($urandom_range(0, 3) == 0);
                wait_n = burst_out ? 0 : $urandom_range(0, 6);
            end
            if (wait_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            outs_seen++;
            @(negedge i_clk);
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cascade_out_q.size() == 0) begin
                $error("result with no request pending: sample_out %0d", o_sample_out);
                err_cnt++;
            end else begin
                head_r = cascade_out_q.pop_front();
                if (o_sample_out !== head_r.smp) begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           head_r.smp, o_sample_out);
                    err_cnt++;
                end
                if (o_block_end !== head_r.last) begin
                    $error("block_end mismatch: expected %0b, actual %0b",
                           head_r.last, o_block_end);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: tape_bias_slew_cascade.f
hdl/tbsc_pkg.sv
hdl/tbsc_state_mem.sv
hdl/tbsc_engine.sv
hdl/tape_bias_slew_cascade.sv
tb/tb_top.sv
